/* src/cdc_pkg.sv */
// Package for the content-defined chunker: register indexes, reset values,
// cut cause codes and hash constants. No dependencies.
package cdc_pkg;

  localparam int unsigned CfgIdxWidth  = 8;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned RegLenWidth  = 17;
  localparam int unsigned HashWidth    = 32;
  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned CauseWidth   = 2;

  // Register indexes on the configuration channel
  localparam logic [CfgIdxWidth-1:0] RegMinChunk    = 8'd0;
  localparam logic [CfgIdxWidth-1:0] RegMaxChunk    = 8'd1;
  localparam logic [CfgIdxWidth-1:0] RegBoundaryMask = 8'd2;
  localparam logic [CfgIdxWidth-1:0] RegTotalLength = 8'd3;

  // Reset values
  localparam logic [RegLenWidth-1:0] MinChunkReset     = 17'(8 * 1024);
  localparam logic [RegLenWidth-1:0] MaxChunkReset     = 17'(64 * 1024);
  localparam logic [HashWidth-1:0]   BoundaryMaskReset = 32'(16 * 1024 - 1);
  localparam logic [HashWidth-1:0]   TotalLengthReset  = 32'd0;

  // hash * 33 is hash * 32 + hash
  localparam int unsigned HashShift = 5;

  typedef enum logic [CauseWidth-1:0] {
    CAUSE_HASH = 2'd0,
    CAUSE_MAX  = 2'd1,
    CAUSE_END  = 2'd2
  } cut_cause_e;

endpackage

/* src/cdc_in_if.sv */
// Input byte channel of the content-defined chunker.
// Carries valid, ready and one stream byte with its end marker.
interface cdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

/* src/cdc_out_if.sv */
// Result channel of the content-defined chunker.
// Carries valid, ready, the closed chunk length, its cut cause and final flag.
interface cdc_out_if #(
  parameter int unsigned LENGTH_WIDTH = 17
);
  logic                    valid;
  logic                    ready;
  logic [LENGTH_WIDTH-1:0] chunk_length;
  logic [1:0]              cut_cause;
  logic                    final_chunk;

  modport source (output valid, output chunk_length, output cut_cause, output final_chunk,
                  input ready);
  modport sink   (input valid, input chunk_length, input cut_cause, input final_chunk,
                  output ready);
endinterface

/* src/cdc_cfg_if.sv */
// Configuration write channel of the content-defined chunker.
// Carries valid, ready, a register index and the write data.
interface cdc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/content_defined_chunker_unit.sv */
// Content-defined chunker top level: rolling hash, chunk length counter and
// a two-entry result queue. Depends on cdc_pkg and the cdc_*_if interfaces.
//
// Usage:
//   in_i   carries one byte per transaction, end_of_input marks the last byte.
//   out_o  carries one transaction per closed chunk: length, cut cause
//          (hash match, maximum length, end of input) and a final flag.
//   cfg_i  writes min_chunk, max_chunk, boundary_mask and total_length by
//          index; it is always ready and unknown indexes are dropped.
// Throughput: one byte per clock while in_i is ready. The hash update (shift,
// add, xor), the mask test and the length compares all sit in the
// combinational logic between the input handshake and the result register.
// Result path: a byte that closes a chunk is registered into the head entry,
// which drives out_o, or into the skid entry while out_o is stalled.
// Stall: while out_o is stalled, one more result fits in the skid entry and
// bytes that close no chunk keep flowing; in_i drops ready only once both
// result entries are full.
// Reset: registers take their reset values, hash and length clear and the
// result queue empties.
module content_defined_chunker_unit #(
  parameter int unsigned LENGTH_WIDTH = 17
) (
  input  logic clk_i,
  input  logic rst_ni,
  cdc_in_if.sink   in_i,
  cdc_out_if.source out_o,
  cdc_cfg_if.sink  cfg_i
);
  import cdc_pkg::*;

  localparam int unsigned CmpWidth =
      (LENGTH_WIDTH > RegLenWidth) ? LENGTH_WIDTH : RegLenWidth;

  typedef struct packed {
    logic [LENGTH_WIDTH-1:0] chunk_length;
    cut_cause_e              cut_cause;
    logic                    final_chunk;
  } result_t;

  // Configuration registers
  logic [RegLenWidth-1:0] min_chunk_q, max_chunk_q;
  logic [HashWidth-1:0]   boundary_mask_q, total_length_q;

  // Chunk state
  logic [HashWidth-1:0]    hash_q, hash_d;
  logic [LENGTH_WIDTH-1:0] run_q, run_d;

  // Result queue: head drives out_o, skid holds one more
  result_t head_q, skid_q, result_d;
  logic    head_valid_q, skid_valid_q;

  logic in_accept, out_pop, cut, one_chunk, at_limit, ge_min, ge_max, hash_hit;
  cut_cause_e cause;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_chunk_q     <= MinChunkReset;
      max_chunk_q     <= MaxChunkReset;
      boundary_mask_q <= BoundaryMaskReset;
      total_length_q  <= TotalLengthReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegMinChunk:     min_chunk_q     <= cfg_i.data[RegLenWidth-1:0];
        RegMaxChunk:     max_chunk_q     <= cfg_i.data[RegLenWidth-1:0];
        RegBoundaryMask: boundary_mask_q <= cfg_i.data[HashWidth-1:0];
        RegTotalLength:  total_length_q  <= cfg_i.data[HashWidth-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = !skid_valid_q;
  assign in_accept  = in_i.valid && in_i.ready;
  assign out_pop    = head_valid_q && out_o.ready;

  always_comb begin
    hash_d = ((hash_q << HashShift) + hash_q) ^ {{(HashWidth-ByteWidth){1'b0}}, in_i.data_byte};
    // saturate at the counter limit
    run_d  = (&run_q) ? run_q : run_q + LENGTH_WIDTH'(1);

    at_limit  = &run_d;
    one_chunk = total_length_q <= {{(HashWidth-RegLenWidth){1'b0}}, max_chunk_q};
    ge_min    = CmpWidth'(run_d) >= CmpWidth'(min_chunk_q);
    ge_max    = CmpWidth'(run_d) >= CmpWidth'(max_chunk_q);
    hash_hit  = (hash_d & boundary_mask_q) == '0;

    cut   = 1'b0;
    cause = CAUSE_HASH;
    if (at_limit) begin
      cut   = 1'b1;
      cause = CAUSE_MAX;
    end else if (!one_chunk && ge_min) begin
      if (ge_max) begin
        cut   = 1'b1;
        cause = CAUSE_MAX;
      end else if (hash_hit) begin
        cut   = 1'b1;
        cause = CAUSE_HASH;
      end
    end
    if (!cut && in_i.end_of_input) begin
      cut   = 1'b1;
      cause = CAUSE_END;
    end

    result_d.chunk_length = run_d;
    result_d.cut_cause    = cause;
    result_d.final_chunk  = in_i.end_of_input;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
      run_q  <= '0;
    end else if (in_accept) begin
      if (cut) begin
        hash_q <= '0;
        run_q  <= '0;
      end else begin
        hash_q <= hash_d;
        run_q  <= run_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_pop || !head_valid_q) begin
      if (skid_valid_q) begin
        head_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        head_valid_q <= in_accept && cut;
      end
    end else if (in_accept && cut) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_pop || !head_valid_q) begin
      if (skid_valid_q) begin
        head_q <= skid_q;
      end else if (in_accept && cut) begin
        head_q <= result_d;
      end
    end else if (in_accept && cut) begin
      skid_q <= result_d;
    end
  end

  assign out_o.valid        = head_valid_q;
  assign out_o.chunk_length = head_q.chunk_length;
  assign out_o.cut_cause    = head_q.cut_cause;
  assign out_o.final_chunk  = head_q.final_chunk;

endmodule
